>>> sv/eip_pkg.sv
// ----------------------------------------------------------------------------
// eip_pkg: shared types and constants of the IPv4 / layer-4 header parser
// Holds the status codes, protocol numbers and the record of captured header
// fields that passes from the capture stage to the summary logic.
// ----------------------------------------------------------------------------
package eip_pkg;

	typedef enum logic [2:0] {
		ST_TCP       = 3'd0,
		ST_UDP       = 3'd1,
		ST_OTHER     = 3'd2,
		ST_BAD_IHL   = 3'd3,
		ST_TRUNC     = 3'd4,
		ST_NEG       = 3'd5
	} parse_status_t;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// Fixed IPv4 header facts and the UDP header size.
	localparam logic [6:0] IP_MIN_HDR_BYTES = 7'd20;
	localparam logic [6:0] UDP_HDR_BYTES    = 7'd8;
	localparam logic [3:0] IHL_MIN_WORDS    = 4'd5;

	// Header fields as they stand once the current byte has been captured.
	typedef struct packed {
		logic [15:0] pos;
		logic [3:0]  ihl_words;
		logic [15:0] total_len;
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [3:0]  tcp_words;
	} hdr_t;

	typedef struct packed {
		parse_status_t status;
		logic [31:0]   src_addr;
		logic [31:0]   dst_addr;
		logic [15:0]   src_port;
		logic [15:0]   dst_port;
		logic [15:0]   payload_len;
	} summary_t;

endpackage

>>> sv/eip_byte_if.sv
// ----------------------------------------------------------------------------
// eip_byte_if: frame byte channel
// Carries one frame byte per request with a flag on the final byte.
// ----------------------------------------------------------------------------
interface eip_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

>>> sv/eip_sum_if.sv
// ----------------------------------------------------------------------------
// eip_sum_if: frame summary channel
// Carries one parse summary per request, one per frame.
// ----------------------------------------------------------------------------
interface eip_sum_if;
	logic        valid;
	logic        ready;
	logic [2:0]  parse_status;
	logic [31:0] source_address;
	logic [31:0] destination_address;
	logic [15:0] source_port;
	logic [15:0] destination_port;
	logic [15:0] payload_length;

	modport source (
		output valid, output parse_status, output source_address,
		output destination_address, output source_port, output destination_port,
		output payload_length, input ready
	);
	modport sink (
		input valid, input parse_status, input source_address,
		input destination_address, input source_port, input destination_port,
		input payload_length, output ready
	);
endinterface

>>> sv/eip_capture.sv
// ----------------------------------------------------------------------------
// eip_capture: byte counter and header field capture
// Holds the per-frame header registers and shows them as they stand once the
// current byte is taken in. State clears after the final byte of a frame.
// ----------------------------------------------------------------------------
module eip_capture #(
	parameter int MAC_HEADER_BYTES = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data,
	input  logic              last,
	output eip_pkg::hdr_t     hdr
);

	localparam logic [15:0] IP_OFS = 16'(MAC_HEADER_BYTES);

	eip_pkg::hdr_t st_q;
	eip_pkg::hdr_t hdr_next;
	logic [15:0]   l4_ofs;

	always_comb begin
		hdr    = st_q;
		l4_ofs = IP_OFS + {10'd0, st_q.ihl_words, 2'b00};

		if (st_q.pos == IP_OFS) begin
			hdr.ihl_words = data[3:0];
		end else if (st_q.pos == IP_OFS + 16'd2) begin
			hdr.total_len = {data, st_q.total_len[7:0]};
		end else if (st_q.pos == IP_OFS + 16'd3) begin
			hdr.total_len = {st_q.total_len[15:8], data};
		end else if (st_q.pos == IP_OFS + 16'd9) begin
			hdr.protocol = data;
		end else if (st_q.pos >= IP_OFS + 16'd12 && st_q.pos < IP_OFS + 16'd16) begin
			hdr.src_addr = {st_q.src_addr[23:0], data};
		end else if (st_q.pos >= IP_OFS + 16'd16 && st_q.pos < IP_OFS + 16'd20) begin
			hdr.dst_addr = {st_q.dst_addr[23:0], data};
		end

		// Layer-4 fields sit after a header of at least the minimum length.
		if (st_q.pos > IP_OFS && st_q.ihl_words >= eip_pkg::IHL_MIN_WORDS) begin
			if (st_q.pos >= l4_ofs && st_q.pos < l4_ofs + 16'd2) begin
				hdr.src_port = {st_q.src_port[7:0], data};
			end else if (st_q.pos >= l4_ofs + 16'd2 && st_q.pos < l4_ofs + 16'd4) begin
				hdr.dst_port = {st_q.dst_port[7:0], data};
			end else if (st_q.pos == l4_ofs + 16'd12) begin
				hdr.tcp_words = data[7:4];
			end
		end

		// The byte counter saturates on very long frames.
		hdr_next     = hdr;
		hdr_next.pos = (st_q.pos == 16'hFFFF) ? st_q.pos : st_q.pos + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			if (last) begin
				st_q <= '0;
			end else begin
				st_q <= hdr_next;
			end
		end
	end

endmodule

>>> sv/eip_summary.sv
// ----------------------------------------------------------------------------
// eip_summary: end-of-frame classification
// Turns the captured header fields at the final byte into a status, the
// reported ports and the payload length.
// ----------------------------------------------------------------------------
module eip_summary #(
	parameter int MAC_HEADER_BYTES = 14
) (
	input  eip_pkg::hdr_t     hdr,
	output eip_pkg::summary_t sum
);

	localparam logic [16:0] IP_OFS = 17'(MAC_HEADER_BYTES);

	logic [16:0] n_bytes;
	logic [5:0]  ihl_bytes;
	logic [16:0] l4_ofs;
	logic [16:0] need;
	logic        is_tcp;
	logic [6:0]  l4_bytes;
	logic [6:0]  hdr_bytes;

	always_comb begin
		n_bytes   = {1'b0, hdr.pos} + 17'd1;
		ihl_bytes = {hdr.ihl_words, 2'b00};
		l4_ofs    = IP_OFS + {11'd0, ihl_bytes};
		is_tcp    = (hdr.protocol == eip_pkg::PROTO_TCP);
		need      = l4_ofs + (is_tcp ? 17'd13 : 17'd4);
		l4_bytes  = is_tcp ? {1'b0, hdr.tcp_words, 2'b00} : eip_pkg::UDP_HDR_BYTES;
		hdr_bytes = {1'b0, ihl_bytes} + l4_bytes;

		sum.src_addr    = hdr.src_addr;
		sum.dst_addr    = hdr.dst_addr;
		sum.src_port    = '0;
		sum.dst_port    = '0;
		sum.payload_len = '0;

		if (n_bytes < IP_OFS + 17'(eip_pkg::IP_MIN_HDR_BYTES)) begin
			sum.status = eip_pkg::ST_TRUNC;
		end else if ({1'b0, ihl_bytes} < eip_pkg::IP_MIN_HDR_BYTES) begin
			sum.status = eip_pkg::ST_BAD_IHL;
		end else if (is_tcp || hdr.protocol == eip_pkg::PROTO_UDP) begin
			if (n_bytes < need) begin
				sum.status = eip_pkg::ST_TRUNC;
			end else begin
				sum.src_port = hdr.src_port;
				sum.dst_port = hdr.dst_port;
				if (hdr.total_len < {9'd0, hdr_bytes}) begin
					sum.status = eip_pkg::ST_NEG;
				end else begin
					sum.status      = is_tcp ? eip_pkg::ST_TCP : eip_pkg::ST_UDP;
					sum.payload_len = hdr.total_len - {9'd0, hdr_bytes};
				end
			end
		end else begin
			sum.status = eip_pkg::ST_OTHER;
		end
	end

endmodule

>>> sv/eth_ipv4_l4_header_parser_core.sv
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_parser_core: streaming Ethernet / IPv4 / TCP-UDP parser
// Counts frame bytes, captures the IPv4 and layer-4 header fields at their
// offsets and gives one summary request at the final byte of every frame.
// ----------------------------------------------------------------------------
//
//   channel   direction  one request carries
//   --------  ---------  ------------------------------------------------------
//   frame     in         frame_byte, frame_last
//   summary   out        parse_status, addresses, ports, payload_length
//
// One frame byte is taken per clock cycle while no final byte is held back. A
// byte passes an input register, then the capture and classification logic,
// and its summary is shown from the output register, which loads as the final
// byte leaves the input register. The output register alone stalls the flow: a
// final byte waits in the input register only while an earlier summary has not
// been taken. Reset clears the byte counter, the header registers and both
// valid flags.
//
module eth_ipv4_l4_header_parser_core #(
	parameter int MAC_HEADER_BYTES = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	eip_byte_if.sink    frame,
	eip_sum_if.source   summary
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Output register.
	logic              out_valid_q;
	eip_pkg::summary_t out_q;

	eip_pkg::hdr_t     hdr;
	eip_pkg::summary_t sum;
	logic              advance;

	// A byte in the input register moves on at once unless it closes a frame
	// and the summary slot is still occupied.
	assign advance     = valid_s1 && (!last_s1 || !out_valid_q || summary.ready);
	assign frame.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			byte_s1 <= frame.frame_byte;
			last_s1 <= frame.frame_last;
		end
	end

	eip_capture #(
		.MAC_HEADER_BYTES (MAC_HEADER_BYTES)
	) u_capture (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data   (byte_s1),
		.last   (last_s1),
		.hdr    (hdr)
	);

	eip_summary #(
		.MAC_HEADER_BYTES (MAC_HEADER_BYTES)
	) u_summary (
		.hdr (hdr),
		.sum (sum)
	);

	// The summary register loads on the final byte of each frame and holds
	// until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (summary.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_q <= sum;
		end
	end

	assign summary.valid               = out_valid_q;
	assign summary.parse_status        = out_q.status;
	assign summary.source_address      = out_q.src_addr;
	assign summary.destination_address = out_q.dst_addr;
	assign summary.source_port         = out_q.src_port;
	assign summary.destination_port    = out_q.dst_port;
	assign summary.payload_length      = out_q.payload_len;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Ethernet / IPv4 / TCP-UDP header parser
// Streams frames one byte per request into the parser and checks each summary
// request against a cycle-free model of the parser. The model runs on every
// accepted byte. Directed frames cover the edge cases, then mostly well-formed
// random frames follow. Both channels idle at random, and a long receiver
// stall fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAC_BYTES   = 14;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       drain;	// do not offer this byte until every summary is back
	} frame_req_t;

	logic clk = 1'b0;
	logic arst_n;

	eip_byte_if frame_ch ();
	eip_sum_if  sum_ch ();

	eth_ipv4_l4_header_parser_core #(
		.MAC_HEADER_BYTES(MAC_BYTES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame_ch),
		.summary (sum_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bytes still to be sent, and summaries the parser owes us, oldest first.
	frame_req_t          byte_backlog[$];
	eip_pkg::summary_t   summaries_due[$];

	// Header state of the frame in flight, as the parser should hold it.
	logic [15:0] hdr_pos = '0;
	logic [3:0]  hdr_ihl = '0;
	logic [15:0] hdr_tot_len = '0;
	logic [7:0]  hdr_proto = '0;
	logic [31:0] hdr_src = '0;
	logic [31:0] hdr_dst = '0;
	logic [15:0] hdr_sport = '0;
	logic [15:0] hdr_dport = '0;
	logic [3:0]  hdr_doff = '0;

	int unsigned frames_queued = 0;
	int unsigned frames_in = 0;
	int unsigned bytes_in = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_cnt = 0;
	int unsigned status_hits[6] = '{default: 0};
	logic        byte_moved = 1'b0;

	// Model of the parser for one accepted byte. On the final byte of a frame
	// it works out the summary, queues it and clears the header state.
	task automatic track_frame_byte(input logic [7:0] b, input logic last);
		int unsigned       pos, n, hdr_bytes, l4, l4_bytes, need;
		logic              is_tcp;
		eip_pkg::summary_t want;

		pos = hdr_pos;
		if (pos == MAC_BYTES) begin
			hdr_ihl = b[3:0];
		end else if (pos == MAC_BYTES + 2) begin
			hdr_tot_len[15:8] = b;
		end else if (pos == MAC_BYTES + 3) begin
			hdr_tot_len[7:0] = b;
		end else if (pos == MAC_BYTES + 9) begin
			hdr_proto = b;
		end else if (pos >= MAC_BYTES + 12 && pos < MAC_BYTES + 16) begin
			hdr_src = {hdr_src[23:0], b};
		end else if (pos >= MAC_BYTES + 16 && pos < MAC_BYTES + 20) begin
			hdr_dst = {hdr_dst[23:0], b};
		end

		// Layer-4 capture only once a usable header length is known.
		if (pos > MAC_BYTES && hdr_ihl >= eip_pkg::IHL_MIN_WORDS) begin
			l4 = MAC_BYTES + int'(hdr_ihl) * 4;
			if (pos >= l4 && pos < l4 + 2) begin
				hdr_sport = {hdr_sport[7:0], b};
			end else if (pos >= l4 + 2 && pos < l4 + 4) begin
				hdr_dport = {hdr_dport[7:0], b};
			end else if (pos == l4 + 12) begin
				hdr_doff = b[7:4];
			end
		end

		if (hdr_pos != 16'hFFFF) begin
			hdr_pos = hdr_pos + 16'd1;
		end
		if (!last) begin
			return;
		end

		n         = pos + 1;
		hdr_bytes = int'(hdr_ihl) * 4;
		l4        = MAC_BYTES + hdr_bytes;
		want          = '0;
		want.src_addr = hdr_src;
		want.dst_addr = hdr_dst;

		// Truncation of the base header wins over a bad length, which wins
		// over the protocol.
		if (n < MAC_BYTES + eip_pkg::IP_MIN_HDR_BYTES) begin
			want.status = eip_pkg::ST_TRUNC;
		end else if (hdr_bytes < eip_pkg::IP_MIN_HDR_BYTES) begin
			want.status = eip_pkg::ST_BAD_IHL;
		end else if (hdr_proto == eip_pkg::PROTO_TCP || hdr_proto == eip_pkg::PROTO_UDP) begin
			is_tcp = (hdr_proto == eip_pkg::PROTO_TCP);
			need   = is_tcp ? l4 + 13 : l4 + 4;
			if (n < need) begin
				want.status = eip_pkg::ST_TRUNC;
			end else begin
				l4_bytes      = is_tcp ? int'(hdr_doff) * 4 : int'(eip_pkg::UDP_HDR_BYTES);
				want.src_port = hdr_sport;
				want.dst_port = hdr_dport;
				if (hdr_tot_len < hdr_bytes + l4_bytes) begin
					want.status = eip_pkg::ST_NEG;
				end else begin
					want.status      = is_tcp ? eip_pkg::ST_TCP : eip_pkg::ST_UDP;
					want.payload_len = 16'(hdr_tot_len - hdr_bytes - l4_bytes);
				end
			end
		end else begin
			want.status = eip_pkg::ST_OTHER;
		end

		summaries_due.push_back(want);
		status_hits[want.status]++;
		hdr_pos     = '0;
		hdr_ihl     = '0;
		hdr_tot_len = '0;
		hdr_proto   = '0;
		hdr_src     = '0;
		hdr_dst     = '0;
		hdr_sport   = '0;
		hdr_dport   = '0;
		hdr_doff    = '0;
	endtask

	// Builds one frame of the given length. The body is random, all ones or
	// all zeros; the IHL, total length, protocol and data offset are then
	// written at their offsets where the frame is long enough to hold them.
	task automatic queue_frame(input int len, input logic [3:0] ihl,
			input logic [15:0] tot, input logic [7:0] proto, input logic [3:0] doff,
			input int fill, input bit drain);
		logic [7:0] fb[$];
		int         l4;
		frame_req_t req;

		for (int i = 0; i < len; i++) begin
			fb.push_back(fill == 1 ? 8'hFF : fill == 2 ? 8'h00 : 8'($urandom));
		end
		if (len > MAC_BYTES) fb[MAC_BYTES] = {fb[MAC_BYTES][7:4], ihl};
		if (len > MAC_BYTES + 2) fb[MAC_BYTES + 2] = tot[15:8];
		if (len > MAC_BYTES + 3) fb[MAC_BYTES + 3] = tot[7:0];
		if (len > MAC_BYTES + 9) fb[MAC_BYTES + 9] = proto;
		l4 = MAC_BYTES + int'(ihl) * 4;
		if (len > l4 + 12) fb[l4 + 12] = {doff, fb[l4 + 12][3:0]};

		for (int i = 0; i < len; i++) begin
			req.data  = fb[i];
			req.last  = (i == len - 1);
			req.drain = drain && (i == 0);
			byte_backlog.push_back(req);
		end
		frames_queued++;
	endtask

	// Header length in words: mostly the plain 5, now and then with options.
	function automatic logic [3:0] pick_words();
		return ($urandom_range(9) < 7) ? 4'd5 : 4'($urandom_range(6, 15));
	endfunction

	// Three frames in four are TCP or UDP with a consistent header, so the
	// parser reaches its port and length logic; a few of those carry a short
	// total length, a wild total length or are cut short. The rest are other
	// protocols, bad header lengths and plain noise.
	task automatic queue_random_frame(input bit drain);
		int          kind, sub, len, need, hdr, l4hdr;
		bit          is_tcp;
		logic [3:0]  ihl, doff;
		logic [15:0] tot;
		logic [7:0]  proto;

		kind  = $urandom_range(99);
		sub   = $urandom_range(99);
		ihl   = pick_words();
		doff  = ($urandom_range(9) == 0) ? 4'($urandom_range(4)) : pick_words();
		tot   = 16'($urandom);
		proto = 8'($urandom);
		if (proto == eip_pkg::PROTO_TCP || proto == eip_pkg::PROTO_UDP) proto = 8'd1;
		len   = $urandom_range(MAC_BYTES + 20, MAC_BYTES + 40);

		if (kind < 75) begin
			is_tcp = 1'($urandom_range(1));
			proto  = is_tcp ? eip_pkg::PROTO_TCP : eip_pkg::PROTO_UDP;
			hdr    = int'(ihl) * 4;
			l4hdr  = is_tcp ? int'(doff) * 4 : int'(eip_pkg::UDP_HDR_BYTES);
			need   = MAC_BYTES + hdr + (is_tcp ? 13 : 4);
			len    = need + $urandom_range(3);
			if (sub < 10) begin
				tot = 16'($urandom_range(hdr + l4hdr - 1));
			end else if (sub >= 15) begin
				tot = 16'(hdr + l4hdr + $urandom_range(6));
				if (MAC_BYTES + int'(tot) > len) len = MAC_BYTES + int'(tot);
			end
			if (sub >= 92) len = $urandom_range(1, need - 1);
		end else if (kind < 85) begin
			// other protocol, already set up above
		end else if (kind < 92) begin
			ihl   = 4'($urandom_range(4));
			proto = $urandom_range(1) ? eip_pkg::PROTO_TCP : eip_pkg::PROTO_UDP;
		end else begin
			len   = $urandom_range(1, 70);
			proto = 8'($urandom);
			ihl   = 4'($urandom);
			doff  = 4'($urandom);
		end
		queue_frame(len, ihl, tot, proto, doff, 0, drain);
	endtask

	// Both sides skip a cycle now and then, except in one calm window.
	function automatic bit take_break(input int unsigned progress);
		return (progress < 17 || progress >= 23) && ($urandom_range(99) < 13);
	endfunction

	// Acceptance of a byte request: run the model on what was on the bus.
	always @(posedge clk) begin
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			track_frame_byte(frame_ch.frame_byte, frame_ch.frame_last);
			void'(byte_backlog.pop_front());
			byte_moved = 1'b1;
			bytes_in++;
			if (frame_ch.frame_last) frames_in++;
		end
	end

	// Byte driver. A pending request stays on the bus until it is taken; a
	// byte marked for drain waits until the parser owes no summary.
	always @(negedge clk) begin
		if (!arst_n) begin
			frame_ch.valid      <= 1'b0;
			frame_ch.frame_byte <= 8'h00;
			frame_ch.frame_last <= 1'b0;
		end else if (!frame_ch.valid || byte_moved) begin
			if (byte_backlog.size() != 0 && !take_break(frames_in) &&
					!(byte_backlog[0].drain && summaries_due.size() != 0)) begin
				frame_ch.valid      <= 1'b1;
				frame_ch.frame_byte <= byte_backlog[0].data;
				frame_ch.frame_last <= byte_backlog[0].last;
			end else begin
				frame_ch.valid      <= 1'b0;
				frame_ch.frame_byte <= 8'($urandom);
				frame_ch.frame_last <= 1'b0;
			end
		end
		byte_moved = 1'b0;
	end

	// Summary receiver. Once, after a handful of summaries, it refuses
	// requests for a long stretch so the parser backs up into its input.
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(negedge clk) begin
		if (!arst_n) begin
			sum_ch.ready <= 1'b0;
		end else begin
			if (!hold_done && results_seen >= 8) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				sum_ch.ready <= 1'b0;
			end else begin
				sum_ch.ready <= !take_break(results_seen);
			end
		end
	end

	// Summary monitor: every accepted summary must match the oldest one due.
	always @(posedge clk) begin
		eip_pkg::summary_t want;
		if (arst_n && sum_ch.valid && sum_ch.ready) begin
			results_seen++;
			if (summaries_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch %0d: summary with none due, status %0d", mismatches,
						sum_ch.parse_status);
				end
			end else begin
				want = summaries_due.pop_front();
				if (sum_ch.parse_status !== want.status ||
						sum_ch.source_address !== want.src_addr ||
						sum_ch.destination_address !== want.dst_addr ||
						sum_ch.source_port !== want.src_port ||
						sum_ch.destination_port !== want.dst_port ||
						sum_ch.payload_length !== want.payload_len) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch %0d at summary %0d:", mismatches, results_seen);
						$display("  want st %0d src %h dst %h sp %h dp %h len %h",
							want.status, want.src_addr, want.dst_addr,
							want.src_port, want.dst_port, want.payload_len);
						$display("  got  st %0d src %h dst %h sp %h dp %h len %h",
							sum_ch.parse_status, sum_ch.source_address,
							sum_ch.destination_address, sum_ch.source_port,
							sum_ch.destination_port, sum_ch.payload_length);
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n              = 1'b0;
		frame_ch.valid      = 1'b0;
		frame_ch.frame_byte = 8'h00;
		frame_ch.frame_last = 1'b0;
		sum_ch.ready        = 1'b0;

		// Directed frames: plain TCP and UDP with all-ones and all-zero bodies,
		// other protocols at both ends of the byte, both kinds of bad header
		// length, short frames cut in the base header and in the layer-4
		// header, negative payloads, maximum header and total lengths and a
		// TCP data offset of zero.
		queue_frame(58, 4'd5, 16'd44, eip_pkg::PROTO_TCP, 4'd5, 1, 1'b0);
		queue_frame(42, 4'd5, 16'd28, eip_pkg::PROTO_UDP, 4'd0, 2, 1'b0);
		queue_frame(34, 4'd5, 16'd20, 8'd1, 4'd0, 0, 1'b0);
		queue_frame(60, 4'd5, 16'd46, 8'hFF, 4'd0, 0, 1'b0);
		queue_frame(34, 4'd5, 16'd20, 8'h00, 4'd0, 0, 1'b0);
		queue_frame(40, 4'd0, 16'd26, eip_pkg::PROTO_TCP, 4'd5, 0, 1'b0);
		queue_frame(40, 4'd4, 16'd26, eip_pkg::PROTO_UDP, 4'd5, 0, 1'b0);
		queue_frame(1, 4'd5, 16'd0, eip_pkg::PROTO_TCP, 4'd5, 0, 1'b0);
		queue_frame(33, 4'd5, 16'd40, eip_pkg::PROTO_TCP, 4'd5, 0, 1'b0);
		queue_frame(46, 4'd5, 16'd40, eip_pkg::PROTO_TCP, 4'd5, 0, 1'b0);
		queue_frame(37, 4'd5, 16'd28, eip_pkg::PROTO_UDP, 4'd5, 0, 1'b0);
		queue_frame(54, 4'd5, 16'd39, eip_pkg::PROTO_TCP, 4'd5, 0, 1'b0);
		queue_frame(42, 4'd5, 16'd27, eip_pkg::PROTO_UDP, 4'd5, 0, 1'b0);
		queue_frame(87, 4'd15, 16'hFFFF, eip_pkg::PROTO_TCP, 4'd15, 0, 1'b0);
		queue_frame(46, 4'd6, 16'hFFFF, eip_pkg::PROTO_UDP, 4'd0, 0, 1'b0);
		queue_frame(47, 4'd5, 16'd30, eip_pkg::PROTO_TCP, 4'd0, 0, 1'b0);

		// Random frames; the sender drains the parser before the first one
		// and once more along the way.
		while (byte_backlog.size() < 1250 || frames_queued < 24) begin
			queue_random_frame(frames_queued == 16 || frames_queued == 21);
		end

		repeat (6) @(posedge clk);
		#2 arst_n = 1'b1;

		while (byte_backlog.size() != 0 || frame_ch.valid || summaries_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		$display("Sent %0d frames in %0d bytes, checked %0d summaries in %0d cycles.",
			frames_in, bytes_in, results_seen, cycle_cnt);
		$display("Status mix tcp %0d udp %0d other %0d bad-ihl %0d trunc %0d neg %0d.",
			status_hits[eip_pkg::ST_TCP], status_hits[eip_pkg::ST_UDP],
			status_hits[eip_pkg::ST_OTHER], status_hits[eip_pkg::ST_BAD_IHL],
			status_hits[eip_pkg::ST_TRUNC], status_hits[eip_pkg::ST_NEG]);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
